FILE: sv/srle_pkg.sv
// Shared types, codes and constant reduction matrices for the Selling reduction engine.
// Has no dependencies; every other file in the project imports it.
package srle_pkg;

    localparam int SW = 40;
    localparam int EW = 16;
    localparam int NS = 6;
    localparam int NL = 36;
    localparam int NC = 9;
    localparam int BEATS = 15;
    localparam logic [15:0] STEP_LIMIT_RESET = 16'd10000;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_SUM   = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    localparam logic [1:0] K_SCALAR = 2'd0;
    localparam logic [1:0] K_LAT    = 2'd1;
    localparam logic [1:0] K_CELL   = 2'd2;

    typedef logic signed [SW-1:0] t_scalar;
    typedef logic signed [EW-1:0] t_entry;
    typedef t_scalar t_svec [NS];
    typedef t_entry  t_lvec [NL];
    typedef t_entry  t_cvec [NC];

    typedef struct packed {
        t_scalar scalar_0;
        t_scalar scalar_1;
        t_scalar scalar_2;
        t_scalar scalar_3;
        t_scalar scalar_4;
        t_scalar scalar_5;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  row;
        t_scalar     value;
        t_entry      col_0;
        t_entry      col_1;
        t_entry      col_2;
        t_entry      col_3;
        t_entry      col_4;
        t_entry      col_5;
        logic [1:0]  status;
        logic [15:0] steps;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic ovf;
    } t_step_flags;

    localparam int LAT_MAT [6][36] = '{
        '{-1,0,0,0,0,0, 1,1,0,0,0,0, 1,0,0,0,1,0, -1,0,0,1,0,0, 1,0,1,0,0,0, 1,0,0,0,0,1},
        '{1,1,0,0,0,0, 0,-1,0,0,0,0, 0,1,0,1,0,0, 0,1,1,0,0,0, 0,-1,0,0,1,0, 0,1,0,0,0,1},
        '{1,0,1,0,0,0, 0,0,1,1,0,0, 0,0,-1,0,0,0, 0,1,1,0,0,0, 0,0,1,0,1,0, 0,0,-1,0,0,1},
        '{1,0,0,-1,0,0, 0,0,1,1,0,0, 0,1,0,1,0,0, 0,0,0,-1,0,0, 0,0,0,1,1,0, 0,0,0,1,0,1},
        '{0,0,1,0,1,0, 0,1,0,0,-1,0, 1,0,0,0,1,0, 0,0,0,1,1,0, 0,0,0,0,-1,0, 0,0,0,0,1,1},
        '{0,1,0,0,0,1, 1,0,0,0,0,1, 0,0,1,0,0,-1, 0,0,0,1,0,1, 0,0,0,0,1,1, 0,0,0,0,0,-1}
    };

    localparam int CELL_MAT [6][9] = '{
        '{-1,-1,0, 0,1,0, 0,0,-1},
        '{1,0,0, -1,-1,0, 0,0,-1},
        '{1,0,0, 0,-1,0, -1,0,-1},
        '{1,0,0, -1,-1,0, -1,0,-1},
        '{-1,-1,0, 0,1,0, 0,-1,-1},
        '{-1,0,-1, 0,-1,-1, 0,0,1}
    };

endpackage

FILE: sv/selling_reduction_engine_unit.sv
// Top level of the Selling reduction engine: step sequencer, state registers and result beats.
// Depends on srle_pkg and srle_step.
//
// Usage: an input transaction on i_valid/o_ready carries six signed Q23.16 scalars.
// The block then performs one reduction step per clock cycle in the shared step unit
// until no scalar is positive or a failure check ends the item: overflow, the step
// limit, or a positive scalar sum after a step.
// The fifteen results then leave on o_valid/i_ready, one transaction per cycle while
// the receiver takes them: six scalars, six lattice transform rows, three cell rows,
// the last one flagged. A new item is accepted only after the last result is taken.
// o_ready is high only while the block is idle; one item is in work at a time.
// A receiver stall holds the current result unchanged until it is taken.
// i_cfg_we writes the step limit in the same cycle; write it only while idle.
// Synchronous reset returns to idle with no result pending and the step limit at 10000.
module selling_reduction_engine_unit
    import srle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} t_state;

    t_state      r_state;
    t_svec       r_scalar;
    t_lvec       r_lat;
    t_cvec       r_cell;
    logic [15:0] r_steps;
    logic [1:0]  r_status;
    logic        r_chk;
    logic [3:0]  r_beat;
    logic [15:0] r_limit;

    t_svec       n_scalar;
    t_lvec       n_lat;
    t_cvec       n_cell;
    t_step_flags n_flags;
    logic [2:0]  n_idx;
    t_scalar     n_max;
    logic signed [SW+2:0] n_sum;
    logic [16:0] n_steps;

    always_comb begin
        n_idx = 3'd0;
        n_max = r_scalar[0];
        n_sum = (SW+3)'(r_scalar[0]);
        for (int i = 1; i < NS; i++) begin
            n_sum = n_sum + (SW+3)'(r_scalar[i]);
            if (r_scalar[i] > n_max) begin
                n_max = r_scalar[i];
                n_idx = 3'(i);
            end
        end
        n_steps = {1'b0, r_steps} + 17'd1;
    end

    srle_step u_step (
        .i_idx    (n_idx),
        .i_scalar (r_scalar),
        .i_lat    (r_lat),
        .i_cell   (r_cell),
        .o_scalar (n_scalar),
        .o_lat    (n_lat),
        .o_cell   (n_cell),
        .o_flags  (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= STEP_LIMIT_RESET;
            r_beat   <= '0;
            r_chk    <= 1'b0;
            r_status <= ST_OK;
            r_steps  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_scalar[0] <= i_data.scalar_0;
                        r_scalar[1] <= i_data.scalar_1;
                        r_scalar[2] <= i_data.scalar_2;
                        r_scalar[3] <= i_data.scalar_3;
                        r_scalar[4] <= i_data.scalar_4;
                        r_scalar[5] <= i_data.scalar_5;
                        for (int i = 0; i < NL; i++) begin
                            r_lat[i] <= (i / NS == i % NS) ? EW'(1) : '0;
                        end
                        for (int i = 0; i < NC; i++) begin
                            r_cell[i] <= (i / 3 == i % 3) ? EW'(1) : '0;
                        end
                        r_steps  <= '0;
                        r_status <= ST_OK;
                        r_chk    <= 1'b0;
                        r_state  <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_beat <= '0;
                    if (r_chk && n_sum > 0) begin
                        r_status <= ST_SUM;
                        r_state  <= S_OUT;
                    end else if (n_max <= 0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_scalar <= n_scalar;
                        r_lat    <= n_lat;
                        r_cell   <= n_cell;
                        r_steps  <= n_steps[16] ? 16'hFFFF : n_steps[15:0];
                        r_chk    <= 1'b1;
                        if (n_flags.ovf) begin
                            r_status <= ST_OVF;
                            r_state  <= S_OUT;
                        end else if (n_steps > {1'b0, r_limit}) begin
                            r_status <= ST_LIMIT;
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_beat == 4'(BEATS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_beat <= r_beat + 4'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        logic [2:0] row;
        o_data        = '0;
        o_data.status = r_status;
        o_data.steps  = r_steps;
        o_data.last   = (r_beat == 4'(BEATS - 1));
        row           = '0;
        if (r_beat < 4'd6) begin
            row          = r_beat[2:0];
            o_data.kind  = K_SCALAR;
            o_data.value = r_scalar[row];
        end else if (r_beat < 4'd12) begin
            row         = 3'(r_beat - 4'd6);
            o_data.kind = K_LAT;
            o_data.col_0 = r_lat[6'(row) * 6'd6 + 6'd0];
            o_data.col_1 = r_lat[6'(row) * 6'd6 + 6'd1];
            o_data.col_2 = r_lat[6'(row) * 6'd6 + 6'd2];
            o_data.col_3 = r_lat[6'(row) * 6'd6 + 6'd3];
            o_data.col_4 = r_lat[6'(row) * 6'd6 + 6'd4];
            o_data.col_5 = r_lat[6'(row) * 6'd6 + 6'd5];
        end else begin
            row         = 3'(r_beat - 4'd12);
            o_data.kind = K_CELL;
            o_data.col_0 = r_cell[4'(row) * 4'd3 + 4'd0];
            o_data.col_1 = r_cell[4'(row) * 4'd3 + 4'd1];
            o_data.col_2 = r_cell[4'(row) * 4'd3 + 4'd2];
        end
        o_data.row = row;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule

FILE: sv/srle_step.sv
// One reduction step: applies the selected matrices to scalars and both transforms.
// Purely combinational; uses srle_pkg for types and the matrix constants.
module srle_step
    import srle_pkg::*;
(
    input  logic [2:0]  i_idx,
    input  t_svec       i_scalar,
    input  t_lvec       i_lat,
    input  t_cvec       i_cell,
    output t_svec       o_scalar,
    output t_lvec       o_lat,
    output t_cvec       o_cell,
    output t_step_flags o_flags
);

    localparam logic signed [SW+1:0] S_HI = {3'b000, {(SW-1){1'b1}}};
    localparam logic signed [SW+1:0] S_LO = {3'b111, {(SW-1){1'b0}}};
    localparam logic signed [EW+1:0] E_HI = {3'b000, {(EW-1){1'b1}}};
    localparam logic signed [EW+1:0] E_LO = {3'b111, {(EW-1){1'b0}}};

    always_comb begin
        logic signed [SW+1:0] sacc;
        logic signed [EW+1:0] eacc;
        int c;
        o_flags.ovf = 1'b0;
        for (int i = 0; i < NS; i++) begin
            sacc = '0;
            for (int k = 0; k < NS; k++) begin
                c = LAT_MAT[i_idx][i*NS+k];
                if (c > 0) begin
                    sacc = sacc + (SW+2)'(i_scalar[k]);
                end else if (c < 0) begin
                    sacc = sacc - (SW+2)'(i_scalar[k]);
                end
            end
            if (sacc > S_HI) begin
                o_scalar[i] = S_HI[SW-1:0];
                o_flags.ovf = 1'b1;
            end else if (sacc < S_LO) begin
                o_scalar[i] = S_LO[SW-1:0];
                o_flags.ovf = 1'b1;
            end else begin
                o_scalar[i] = sacc[SW-1:0];
            end
            for (int j = 0; j < NS; j++) begin
                eacc = '0;
                for (int k = 0; k < NS; k++) begin
                    c = LAT_MAT[i_idx][i*NS+k];
                    if (c > 0) begin
                        eacc = eacc + (EW+2)'(i_lat[k*NS+j]);
                    end else if (c < 0) begin
                        eacc = eacc - (EW+2)'(i_lat[k*NS+j]);
                    end
                end
                if (eacc > E_HI) begin
                    o_lat[i*NS+j] = E_HI[EW-1:0];
                    o_flags.ovf = 1'b1;
                end else if (eacc < E_LO) begin
                    o_lat[i*NS+j] = E_LO[EW-1:0];
                    o_flags.ovf = 1'b1;
                end else begin
                    o_lat[i*NS+j] = eacc[EW-1:0];
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                eacc = '0;
                for (int k = 0; k < 3; k++) begin
                    c = CELL_MAT[i_idx][i*3+k];
                    if (c > 0) begin
                        eacc = eacc + (EW+2)'(i_cell[k*3+j]);
                    end else if (c < 0) begin
                        eacc = eacc - (EW+2)'(i_cell[k*3+j]);
                    end
                end
                if (eacc > E_HI) begin
                    o_cell[i*3+j] = E_HI[EW-1:0];
                    o_flags.ovf = 1'b1;
                end else if (eacc < E_LO) begin
                    o_cell[i*3+j] = E_LO[EW-1:0];
                    o_flags.ovf = 1'b1;
                end else begin
                    o_cell[i*3+j] = eacc[EW-1:0];
                end
            end
        end
    end

endmodule

FILE: sv/srle_checker.sv
// Port-level checker for the Selling reduction engine, bound to the top level.
// Depends on srle_pkg and selling_reduction_engine_unit.
module srle_checker
    import srle_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input t_out_item   o_data
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while results pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("ready right after accept");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result changed under stall");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.last) |=> !o_valid)
        else $error("result after last");

    a_scalar_cols_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind == K_SCALAR) |-> (o_data.col_0 == '0 && o_data.col_5 == '0))
        else $error("scalar result with matrix entries");

endmodule

bind selling_reduction_engine_unit srle_checker u_srle_checker (.*);

FILE: tb/tb_selling_reduction_engine_unit.sv
// Self-checking testbench for selling_reduction_engine_unit: directed rows, then random phases.
// Depends on srle_pkg and the engine RTL; a built-in predictor checks every result transaction.
module tb_selling_reduction_engine_unit;
    import srle_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint MAXL = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint MINL = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
    localparam int WATCHDOG_LIMIT = 300000;

    typedef struct {
        t_in_item   stim;
        bit         typed;
        logic [1:0] st;
        logic [15:0] nsteps;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_data;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_data;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    t_out_item   expected_results[$];
    logic [15:0] step_limit_model;
    int          mismatches;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          row_typed;
    logic [1:0]  row_status;
    logic [15:0] row_steps;
    t_row        directed[$];

    selling_reduction_engine_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat_acc(longint a, longint b, int coef, ref bit ov);
        if (coef > 0) begin
            if (b > 0 && a > MAXL - b) begin ov = 1; return MAXL; end
            if (b < 0 && a < MINL - b) begin ov = 1; return MINL; end
            return a + b;
        end
        if (coef < 0) begin
            if (b < 0 && a > MAXL + b) begin ov = 1; return MAXL; end
            if (b > 0 && a < MINL + b) begin ov = 1; return MINL; end
            return a - b;
        end
        return a;
    endfunction

    function automatic longint clamp_to(longint v, int w, ref bit ov);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin ov = 1; return hi; end
        if (v < lo) begin ov = 1; return lo; end
        return v;
    endfunction

    function automatic void predict_reduction(t_in_item it, logic [15:0] lim);
        longint sc[6], ns[6], lt[36], nl[36], ct[9], nc[9];
        longint mx, acc_v, sum;
        int idx, steps;
        logic [1:0] code;
        bit ov, dummy;
        t_out_item r;
        sc[0] = it.scalar_0; sc[1] = it.scalar_1; sc[2] = it.scalar_2;
        sc[3] = it.scalar_3; sc[4] = it.scalar_4; sc[5] = it.scalar_5;
        foreach (lt[i]) lt[i] = (i % 7 == 0) ? 1 : 0;
        foreach (ct[i]) ct[i] = (i % 4 == 0) ? 1 : 0;
        steps = 0;
        code = ST_OK;
        forever begin
            idx = 0;
            mx = sc[0];
            for (int i = 1; i < 6; i++) if (sc[i] > mx) begin mx = sc[i]; idx = i; end
            if (mx <= 0) break;
            ov = 0;
            for (int i = 0; i < 6; i++) begin
                acc_v = 0;
                for (int k = 0; k < 6; k++) acc_v = sat_acc(acc_v, sc[k], LAT_MAT[idx][i*6+k], ov);
                ns[i] = clamp_to(acc_v, SW, ov);
                for (int j = 0; j < 6; j++) begin
                    acc_v = 0;
                    for (int k = 0; k < 6; k++)
                        acc_v = sat_acc(acc_v, lt[k*6+j], LAT_MAT[idx][i*6+k], ov);
                    nl[i*6+j] = clamp_to(acc_v, EW, ov);
                end
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    acc_v = 0;
                    for (int k = 0; k < 3; k++)
                        acc_v = sat_acc(acc_v, ct[k*3+j], CELL_MAT[idx][i*3+k], ov);
                    nc[i*3+j] = clamp_to(acc_v, EW, ov);
                end
            sc = ns; lt = nl; ct = nc;
            steps++;
            if (ov) begin code = ST_OVF; break; end
            if (steps > lim) begin code = ST_LIMIT; break; end
            sum = 0;
            dummy = 0;
            for (int i = 0; i < 6; i++) sum = sat_acc(sum, sc[i], 1, dummy);
            if (sum > 0) begin code = ST_SUM; break; end
        end
        for (int b = 0; b < BEATS; b++) begin
            r = '0;
            if (b < 6) begin
                r.kind = K_SCALAR;
                r.row = 3'(b);
                r.value = sc[b][SW-1:0];
            end else if (b < 12) begin
                r.kind = K_LAT;
                r.row = 3'(b - 6);
                r.col_0 = lt[(b-6)*6+0][EW-1:0];
                r.col_1 = lt[(b-6)*6+1][EW-1:0];
                r.col_2 = lt[(b-6)*6+2][EW-1:0];
                r.col_3 = lt[(b-6)*6+3][EW-1:0];
                r.col_4 = lt[(b-6)*6+4][EW-1:0];
                r.col_5 = lt[(b-6)*6+5][EW-1:0];
            end else begin
                r.kind = K_CELL;
                r.row = 3'(b - 12);
                r.col_0 = ct[(b-12)*3+0][EW-1:0];
                r.col_1 = ct[(b-12)*3+1][EW-1:0];
                r.col_2 = ct[(b-12)*3+2][EW-1:0];
            end
            r.status = code;
            r.steps = (steps > 65535) ? 16'hFFFF : steps[15:0];
            r.last = (b == BEATS - 1);
            if (row_typed) begin
                r.status = row_status;
                r.steps = row_steps;
            end
            expected_results.insert(expected_results.size(), r);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_valid && o_ready) predict_reduction(i_data, step_limit_model);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result transaction: %p", o_data);
                end else begin
                    want = expected_results.pop_front();
                    if (o_data.kind !== want.kind || o_data.row !== want.row
                        || o_data.value !== want.value || o_data.col_0 !== want.col_0
                        || o_data.col_1 !== want.col_1 || o_data.col_2 !== want.col_2
                        || o_data.col_3 !== want.col_3 || o_data.col_4 !== want.col_4
                        || o_data.col_5 !== want.col_5 || o_data.status !== want.status
                        || o_data.steps !== want.steps || o_data.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result mismatch:\n  expected %p\n  actual   %p", want, o_data);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (recv_stall_pct == 0) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with no transaction accepted.");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_in_item make_item(t_scalar a, t_scalar b, t_scalar c,
                                           t_scalar d, t_scalar e, t_scalar f);
        t_in_item it;
        it.scalar_0 = a; it.scalar_1 = b; it.scalar_2 = c;
        it.scalar_3 = d; it.scalar_4 = e; it.scalar_5 = f;
        return it;
    endfunction

    function automatic t_row plain_row(t_in_item it);
        t_row rw;
        rw.stim = it;
        rw.typed = 0;
        rw.st = ST_OK;
        rw.nsteps = '0;
        return rw;
    endfunction

    function automatic t_row typed_row(t_in_item it, logic [1:0] st, logic [15:0] n);
        t_row rw;
        rw.stim = it;
        rw.typed = 1;
        rw.st = st;
        rw.nsteps = n;
        return rw;
    endfunction

    function automatic t_scalar random_full();
        return t_scalar'({$urandom(), $urandom()});
    endfunction

    function automatic t_in_item random_well_formed();
        longint v[6];
        longint sum;
        int mag, j;
        t_in_item it;
        mag = $urandom_range(36, 8);
        sum = 0;
        for (int i = 0; i < 6; i++) begin
            v[i] = longint'($urandom_range((1 << 16) - 1)) <<< (mag - 16);
            v[i] = v[i] + $urandom_range(255);
            if ($urandom_range(99) < 60) v[i] = -v[i];
            sum += v[i];
        end
        if (sum >= 0) begin
            j = $urandom_range(5);
            v[j] = v[j] - sum - 1 - $urandom_range(1000);
        end
        it = make_item(t_scalar'(v[0]), t_scalar'(v[1]), t_scalar'(v[2]),
                       t_scalar'(v[3]), t_scalar'(v[4]), t_scalar'(v[5]));
        return it;
    endfunction

    task automatic send_item(t_in_item it, bit typed, logic [1:0] st, logic [15:0] n);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        row_typed <= typed;
        row_status <= st;
        row_steps <= n;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_and_configure(logic [15:0] lim);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= lim;
        step_limit_model <= lim;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [15:0] lim, int snd, int rcv, int count, int wf_pct);
        drain_and_configure(lim);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < wf_pct) send_item(random_well_formed(), 0, ST_OK, '0);
            else send_item(make_item(random_full(), random_full(), random_full(),
                                     random_full(), random_full(), random_full()), 0, ST_OK, '0);
        end
    endtask

    initial begin
        t_scalar pos_max;
        t_scalar neg_min;
        t_scalar one;
        t_scalar parts[6];
        pos_max = {1'b0, {(SW-1){1'b1}}};
        neg_min = {1'b1, {(SW-1){1'b0}}};
        one = t_scalar'(1) <<< 16;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        row_typed = 0;
        row_status = ST_OK;
        row_steps = '0;
        mismatches = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        step_limit_model = STEP_LIMIT_RESET;

        directed.insert(directed.size(), typed_row(make_item(0, 0, 0, 0, 0, 0), ST_OK, 0));
        directed.insert(directed.size(), typed_row(make_item(neg_min, neg_min, neg_min,
                                                   neg_min, neg_min, neg_min), ST_OK, 0));
        directed.insert(directed.size(), typed_row(make_item(pos_max, pos_max, pos_max,
                                                   pos_max, pos_max, pos_max), ST_OVF, 1));
        directed.insert(directed.size(), typed_row(make_item(pos_max, neg_min, neg_min,
                                                   neg_min, neg_min, neg_min), ST_OVF, 1));
        directed.insert(directed.size(), typed_row(make_item(one, 0, 0, 0, 0, 0), ST_SUM, 1));
        for (int k = 0; k < 6; k++) begin
            foreach (parts[i]) parts[i] = -3 * one;
            parts[k] = 5 * one;
            directed.insert(directed.size(), plain_row(make_item(parts[0], parts[1], parts[2],
                                                       parts[3], parts[4], parts[5])));
        end
        directed.insert(directed.size(),
                        plain_row(make_item(-one, 2 * one, -one, 2 * one, -one, -4 * one)));
        directed.insert(directed.size(),
                        plain_row(make_item(-7 * one, -one, -2 * one, -one, -3 * one, one)));
        directed.insert(directed.size(),
                        plain_row(make_item(-9 * one, 3 * one, -one, -2 * one, one, -one)));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[n])
            send_item(directed[n].stim, directed[n].typed, directed[n].st, directed[n].nsteps);
        i_valid <= 1'b0;
        row_typed <= 0;
        @(negedge i_clk);

        run_phase(16'd0, 0, 0, 15, 0);
        run_phase(16'hFFFF, 0, 0, 6, 100);
        run_phase(16'd1, 80, 0, 30, 50);
        run_phase(16'd300, 0, 80, 60, 85);
        run_phase(16'd40, 18, 18, 60, 75);
        run_phase(16'd1000, 0, 0, 50, 80);
        i_valid <= 1'b0;

        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
